// ===== design/dtmf_pkg.sv =====
// Package for the DTMF tone generator: widths, command codes, phase steps,
// the quarter-wave sine table and the keypad decode.
// Depends on nothing; used by the channel interfaces and the top level.
package dtmf_pkg;

  localparam int SAMPLES_PER_SEC = 8000;
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 8;

  localparam int ROM_N      = 1 << TABLE_ADDR_BITS;
  localparam int ROM_ADDR_W = TABLE_ADDR_BITS + 1;
  localparam int KEY_W      = 8;
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 15;
  localparam int LENGTH_W   = 13;

  localparam logic [LENGTH_W-1:0] TONE_LENGTH_RESET = LENGTH_W'(4000);

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    phase_t row_step;
    phase_t col_step;
  } tone_steps_t;

  localparam phase_t STEP_697 =
    PHASE_BITS'(((64'd697 << PHASE_BITS) + 64'(SAMPLES_PER_SEC / 2)) / 64'(SAMPLES_PER_SEC));
  localparam phase_t STEP_770 =
    PHASE_BITS'(((64'd770 << PHASE_BITS) + 64'(SAMPLES_PER_SEC / 2)) / 64'(SAMPLES_PER_SEC));
  localparam phase_t STEP_852 =
    PHASE_BITS'(((64'd852 << PHASE_BITS) + 64'(SAMPLES_PER_SEC / 2)) / 64'(SAMPLES_PER_SEC));
  localparam phase_t STEP_941 =
    PHASE_BITS'(((64'd941 << PHASE_BITS) + 64'(SAMPLES_PER_SEC / 2)) / 64'(SAMPLES_PER_SEC));
  localparam phase_t STEP_1209 =
    PHASE_BITS'(((64'd1209 << PHASE_BITS) + 64'(SAMPLES_PER_SEC / 2)) / 64'(SAMPLES_PER_SEC));
  localparam phase_t STEP_1336 =
    PHASE_BITS'(((64'd1336 << PHASE_BITS) + 64'(SAMPLES_PER_SEC / 2)) / 64'(SAMPLES_PER_SEC));
  localparam phase_t STEP_1477 =
    PHASE_BITS'(((64'd1477 << PHASE_BITS) + 64'(SAMPLES_PER_SEC / 2)) / 64'(SAMPLES_PER_SEC));
  localparam phase_t STEP_1633 =
    PHASE_BITS'(((64'd1633 << PHASE_BITS) + 64'(SAMPLES_PER_SEC / 2)) / 64'(SAMPLES_PER_SEC));

  // One Taylor term from the previous one, before the factorial division.
  function automatic logic [63:0] taylor_next(input logic [63:0] prev, input logic [63:0] x);
    logic [63:0] t;
    t = (prev * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  function automatic logic [MAG_W-1:0] rom_entry(input int i);
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    logic [63:0] v;
    x = ((64'(i) * HALF_PI_Q30) + 64'(ROM_N >> 1)) >> TABLE_ADDR_BITS;
    term = x;
    sum = longint'(x);
    term = taylor_next(term, x) / 64'd6;   sum = sum - longint'(term);
    term = taylor_next(term, x) / 64'd20;  sum = sum + longint'(term);
    term = taylor_next(term, x) / 64'd42;  sum = sum - longint'(term);
    term = taylor_next(term, x) / 64'd72;  sum = sum + longint'(term);
    term = taylor_next(term, x) / 64'd110; sum = sum - longint'(term);
    term = taylor_next(term, x) / 64'd156; sum = sum + longint'(term);
    term = taylor_next(term, x) / 64'd210; sum = sum - longint'(term);
    term = taylor_next(term, x) / 64'd272; sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = ((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

  typedef logic [MAG_W-1:0] sine_rom_t [0:ROM_N];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int i = 0; i <= ROM_N; i++) begin
      r[i] = rom_entry(i);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // The top two phase bits pick the quadrant; the next bits index the table.
  function automatic sample_t sine_of(input phase_t phase);
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [ROM_ADDR_W-1:0]      addr;
    logic [MAG_W-1:0]           mag;
    quad = phase[PHASE_BITS-1 -: 2];
    idx  = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    addr = quad[0] ? (ROM_ADDR_W'(ROM_N) - {1'b0, idx}) : {1'b0, idx};
    mag  = SINE_ROM[addr];
    return quad[1] ? -sample_t'({1'b0, mag}) : sample_t'({1'b0, mag});
  endfunction

  function automatic tone_steps_t steps_for_key(input logic [KEY_W-1:0] key);
    tone_steps_t s;
    s.col_step = STEP_1633;
    s.row_step = STEP_941;
    case (key)
      "1":      begin s.col_step = STEP_1209; s.row_step = STEP_697; end
      "2":      begin s.col_step = STEP_1336; s.row_step = STEP_697; end
      "3":      begin s.col_step = STEP_1477; s.row_step = STEP_697; end
      "A", "a": begin s.col_step = STEP_1633; s.row_step = STEP_697; end
      "4":      begin s.col_step = STEP_1209; s.row_step = STEP_770; end
      "5":      begin s.col_step = STEP_1336; s.row_step = STEP_770; end
      "6":      begin s.col_step = STEP_1477; s.row_step = STEP_770; end
      "B", "b": begin s.col_step = STEP_1633; s.row_step = STEP_770; end
      "7":      begin s.col_step = STEP_1209; s.row_step = STEP_852; end
      "8":      begin s.col_step = STEP_1336; s.row_step = STEP_852; end
      "9":      begin s.col_step = STEP_1477; s.row_step = STEP_852; end
      "C", "c": begin s.col_step = STEP_1633; s.row_step = STEP_852; end
      "*":      begin s.col_step = STEP_1209; s.row_step = STEP_941; end
      "0":      begin s.col_step = STEP_1336; s.row_step = STEP_941; end
      "#":      begin s.col_step = STEP_1477; s.row_step = STEP_941; end
      default:  begin s.col_step = STEP_1633; s.row_step = STEP_941; end
    endcase
    return s;
  endfunction

endpackage

// ===== design/dtmf_if.sv =====
// Valid/ready channel interfaces for the DTMF tone generator: the command
// channel and the sample channel. Depends on dtmf_pkg.
interface dtmf_cmd_if;
  import dtmf_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [KEY_W-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink (input valid, input command, input key, output ready);
endinterface

interface dtmf_smp_if;
  import dtmf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

// ===== design/dtmf_tone_generator_top.sv =====
// DTMF tone generator top level: keypad decode, two phase accumulators,
// quarter-wave sine lookup and the sample output register.
// Depends on dtmf_pkg and the interfaces in dtmf_if.sv.
//
//   channel   direction  payload          beat meaning
//   cmd       in         command, key     start a tone or request a sample
//   smp       out        sample, last     one averaged two-tone sample
//   cfg       in         cfg_wdata        tone length in samples
//
// A sample beat goes from the phase registers through the sine table and the
// averaging add into the output register.
// A new command beat is taken every cycle while the output register is empty
// or is being drained. A start beat gives no sample beat.
// Reset clears the phases, steps and tone state and sets the tone length to 4000.
module dtmf_tone_generator_top (
  input  logic                           clk,
  input  logic                           rst,
  dtmf_cmd_if.sink                       cmd,
  dtmf_smp_if.source                     smp,
  input  logic                           cfg_wen,
  input  logic [dtmf_pkg::LENGTH_W-1:0]  cfg_wdata
);
  import dtmf_pkg::*;

  logic [LENGTH_W-1:0] tone_length;
  phase_t              row_phase;
  phase_t              col_phase;
  phase_t              row_step;
  phase_t              col_step;
  logic [LENGTH_W-1:0] samples_left;
  logic                active;
  logic                out_valid;
  sample_t             out_sample;
  logic                out_last;

  logic                 accept;
  logic                 fin;
  tone_steps_t          key_steps;
  logic signed [SAMPLE_W:0] sine_sum;
  sample_t              avg;

  assign cmd.ready  = !out_valid || smp.ready;
  assign accept     = cmd.valid && cmd.ready;
  assign smp.valid  = out_valid;
  assign smp.sample = out_sample;
  assign smp.last   = out_last;

  always_comb begin
    key_steps = steps_for_key(cmd.key);
    sine_sum  = (SAMPLE_W+1)'(sine_of(row_phase)) + (SAMPLE_W+1)'(sine_of(col_phase));
    avg       = SAMPLE_W'(sine_sum >>> 1);
    fin       = (samples_left <= LENGTH_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_length  <= TONE_LENGTH_RESET;
      row_phase    <= '0;
      col_phase    <= '0;
      row_step     <= '0;
      col_step     <= '0;
      samples_left <= '0;
      active       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        tone_length <= cfg_wdata;
      end
      if (accept && cmd.command == CMD_SAMPLE) begin
        out_valid <= 1'b1;
      end else if (smp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (cmd.command == CMD_START) begin
          row_step     <= key_steps.row_step;
          col_step     <= key_steps.col_step;
          row_phase    <= '0;
          col_phase    <= '0;
          samples_left <= tone_length;
          active       <= (tone_length != '0);
        end else begin
          if (active) begin
            row_phase    <= row_phase + row_step;
            col_phase    <= col_phase + col_step;
            samples_left <= fin ? '0 : samples_left - LENGTH_W'(1);
            active       <= !fin;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.command == CMD_SAMPLE) begin
      out_sample <= active ? avg : '0;
      out_last   <= active && fin;
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench for dtmf_tone_generator_top: a directed script of command beats, then
// random tones under several tone lengths, with every sample beat checked against an in-bench
// tone predictor or a value set in the script. Depends on dtmf_pkg and the channel interfaces.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtmf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 150;
  localparam int PHASE_ITEMS  = 68;

  typedef enum logic [1:0] {ROW_LENGTH, ROW_BEAT, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic      command;
    int        arg;
    sample_t   want_sample;
    logic      want_last;
  } script_row_t;

  typedef struct packed {
    sample_t sample;
    logic    last;
  } tone_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen;
  logic [LENGTH_W-1:0] cfg_wdata;

  dtmf_cmd_if cmd_ch ();
  dtmf_smp_if smp_ch ();

  dtmf_tone_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .smp       (smp_ch),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [LENGTH_W-1:0] tone_len;
  phase_t              row_acc, col_acc, row_inc, col_inc;
  logic [LENGTH_W-1:0] samples_to_go;
  logic                tone_on;
  logic [MAG_W-1:0]    quarter_sine [0:ROM_N];

  tone_out_t   pending_samples [$];
  script_row_t script [$];
  int          errors = 0;
  int          cycles = 0;
  int          squeeze_req = 0;
  int          squeeze_done = 0;
  int          tx_calm = 0;
  int          rx_calm = 0;

  function automatic logic [MAG_W-1:0] quarter_sine_entry(input int i);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] mag;
    longint      acc;
    x = ((64'(i) * HALF_PI_Q30) + 64'(ROM_N / 2)) >> TABLE_ADDR_BITS;
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    mag = ((64'(acc) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[MAG_W-1:0];
  endfunction

  function automatic int wave(input phase_t p);
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] addr;
    int                         mag;
    quad = p[PHASE_BITS-1 -: 2];
    addr = p[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    mag = quad[0] ? int'(quarter_sine[ROM_N - int'(addr)]) : int'(quarter_sine[addr]);
    return quad[1] ? -mag : mag;
  endfunction

  function automatic phase_t hz_to_step(input int hz);
    logic [63:0] num;
    num = (64'(hz) << PHASE_BITS) + 64'(SAMPLES_PER_SEC / 2);
    return phase_t'(num / 64'(SAMPLES_PER_SEC));
  endfunction

  // Returns 1 when the beat produces a sample beat, with its value in s and l.
  function automatic bit predict_beat(input logic c, input logic [KEY_W-1:0] k,
                                      output sample_t s, output logic l);
    int row_hz;
    int col_hz;
    int sum;
    s = '0;
    l = 1'b0;
    if (c == CMD_START) begin
      row_hz = 941;
      col_hz = 1633;
      case (k)
        "1": begin col_hz = 1209; row_hz = 697; end
        "2": begin col_hz = 1336; row_hz = 697; end
        "3": begin col_hz = 1477; row_hz = 697; end
        "A", "a": begin col_hz = 1633; row_hz = 697; end
        "4": begin col_hz = 1209; row_hz = 770; end
        "5": begin col_hz = 1336; row_hz = 770; end
        "6": begin col_hz = 1477; row_hz = 770; end
        "B", "b": begin col_hz = 1633; row_hz = 770; end
        "7": begin col_hz = 1209; row_hz = 852; end
        "8": begin col_hz = 1336; row_hz = 852; end
        "9": begin col_hz = 1477; row_hz = 852; end
        "C", "c": begin col_hz = 1633; row_hz = 852; end
        "*": begin col_hz = 1209; row_hz = 941; end
        "0": begin col_hz = 1336; row_hz = 941; end
        "#": begin col_hz = 1477; row_hz = 941; end
        default: begin col_hz = 1633; row_hz = 941; end
      endcase
      row_inc = hz_to_step(row_hz);
      col_inc = hz_to_step(col_hz);
      row_acc = '0;
      col_acc = '0;
      samples_to_go = tone_len;
      tone_on = (tone_len != '0);
      return 1'b0;
    end
    if (!tone_on) begin
      return 1'b1;
    end
    sum = wave(row_acc) + wave(col_acc);
    s = sample_t'(sum >>> 1);
    l = (samples_to_go <= 1);
    row_acc = row_acc + row_inc;
    col_acc = col_acc + col_inc;
    samples_to_go = l ? '0 : samples_to_go - 1'b1;
    if (l) begin
      tone_on = 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    string keypad;
    keypad = "0123456789*#ABCDabcd";
    if ($urandom_range(0, 9) < 7) begin
      return keypad[$urandom_range(0, keypad.len() - 1)];
    end
    return KEY_W'($urandom_range(0, 255));
  endfunction

  task automatic report(input string msg);
    $display("cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic void add_row(input row_kind_t kind, input logic c, input int arg,
                                  input int ws, input logic wl);
    script_row_t row;
    row.kind = kind;
    row.command = c;
    row.arg = arg;
    row.want_sample = sample_t'(ws);
    row.want_last = wl;
    script.push_back(row);
  endfunction

  task automatic issue(input logic c, input logic [KEY_W-1:0] k, input bit known,
                       input sample_t ks, input logic kl);
    int        gap;
    sample_t   s;
    logic      l;
    tone_out_t want;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= c;
    cmd_ch.key <= k;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    if (predict_beat(c, k, s, l)) begin
      if (known) begin
        want.sample = ks;
        want.last = kl;
      end else begin
        want.sample = s;
        want.last = l;
      end
      pending_samples.push_back(want);
    end
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_tone_length(input int len);
    settle();
    cfg_wen <= 1'b1;
    cfg_wdata <= LENGTH_W'(len);
    @(posedge clk);
    cfg_wen <= 1'b0;
    tone_len = LENGTH_W'(len);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    tone_out_t want;
    if (!rst && smp_ch.valid === 1'b1 && smp_ch.ready === 1'b1) begin
      if (pending_samples.size() == 0) begin
        report($sformatf("unexpected sample beat %0d last %0b", smp_ch.sample, smp_ch.last));
      end else begin
        want = pending_samples.pop_front();
        if (smp_ch.sample !== want.sample) begin
          report($sformatf("sample %0d, expected %0d", smp_ch.sample, want.sample));
        end
        if (smp_ch.last !== want.last) begin
          report($sformatf("last %0b, expected %0b", smp_ch.last, want.last));
        end
      end
    end
  end

  initial begin
    int hold;
    smp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req != squeeze_done) begin
        squeeze_done++;
        smp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        hold = pick_gap(rx_calm);
        if (hold > 0) begin
          smp_ch.ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
      end
      smp_ch.ready <= 1'b1;
    end
  end

  initial begin
    int  lens [6];
    int  len;
    int  sent;
    int  n;
    bit  squeezed;
    cmd_ch.valid <= 1'b0;
    cmd_ch.command <= CMD_START;
    cmd_ch.key <= '0;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    for (int i = 0; i <= ROM_N; i++) begin
      quarter_sine[i] = quarter_sine_entry(i);
    end
    tone_len = TONE_LENGTH_RESET;
    row_acc = '0;
    col_acc = '0;
    row_inc = '0;
    col_inc = '0;
    samples_to_go = '0;
    tone_on = 1'b0;

    add_row(ROW_KNOWN,  CMD_SAMPLE, 8'hFF, 0, 1'b0);
    add_row(ROW_BEAT,   CMD_START,  "5",   0, 1'b0);
    add_row(ROW_KNOWN,  CMD_SAMPLE, 8'h00, 0, 1'b0);
    add_row(ROW_BEAT,   CMD_SAMPLE, 8'hFF, 0, 1'b0);
    add_row(ROW_BEAT,   CMD_SAMPLE, 8'h00, 0, 1'b0);
    add_row(ROW_BEAT,   CMD_SAMPLE, 8'hA5, 0, 1'b0);
    add_row(ROW_BEAT,   CMD_START,  "a",   0, 1'b0);
    add_row(ROW_KNOWN,  CMD_SAMPLE, 8'h5A, 0, 1'b0);
    add_row(ROW_BEAT,   CMD_SAMPLE, 8'h00, 0, 1'b0);
    add_row(ROW_LENGTH, CMD_START,  1,     0, 1'b0);
    add_row(ROW_BEAT,   CMD_START,  "#",   0, 1'b0);
    add_row(ROW_KNOWN,  CMD_SAMPLE, 8'h00, 0, 1'b1);
    add_row(ROW_KNOWN,  CMD_SAMPLE, 8'h00, 0, 1'b0);
    add_row(ROW_LENGTH, CMD_START,  0,     0, 1'b0);
    add_row(ROW_BEAT,   CMD_START,  8'hFF, 0, 1'b0);
    add_row(ROW_KNOWN,  CMD_SAMPLE, 8'h00, 0, 1'b0);
    add_row(ROW_LENGTH, CMD_START,  8191,  0, 1'b0);
    add_row(ROW_BEAT,   CMD_START,  8'h00, 0, 1'b0);
    add_row(ROW_KNOWN,  CMD_SAMPLE, 8'h00, 0, 1'b0);
    add_row(ROW_BEAT,   CMD_SAMPLE, 8'h00, 0, 1'b0);
    add_row(ROW_LENGTH, CMD_START,  3,     0, 1'b0);
    add_row(ROW_BEAT,   CMD_START,  "D",   0, 1'b0);
    add_row(ROW_KNOWN,  CMD_SAMPLE, 8'h00, 0, 1'b0);
    add_row(ROW_BEAT,   CMD_SAMPLE, 8'h00, 0, 1'b0);
    add_row(ROW_BEAT,   CMD_SAMPLE, 8'h00, 0, 1'b0);
    add_row(ROW_KNOWN,  CMD_SAMPLE, 8'h00, 0, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_LENGTH: begin
          load_tone_length(script[i].arg);
        end
        ROW_KNOWN: begin
          issue(script[i].command, KEY_W'(script[i].arg), 1'b1,
                script[i].want_sample, script[i].want_last);
        end
        default: begin
          issue(script[i].command, KEY_W'(script[i].arg), 1'b0, '0, 1'b0);
        end
      endcase
    end

    lens = '{1, 0, 0, 8191, 0, 0};
    squeezed = 1'b0;
    foreach (lens[p]) begin
      len = (lens[p] == 0) ? $urandom_range(2, 24) : lens[p];
      load_tone_length(len);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (p == 1 && !squeezed && sent >= 10) begin
          squeezed = 1'b1;
          squeeze_req++;
        end
        if ($urandom_range(0, 9) < 8) begin
          issue(CMD_START, pick_key(), 1'b0, '0, 1'b0);
          n = $urandom_range(0, ((len > 30) ? 30 : len) + 2);
          for (int j = 0; j < n; j++) begin
            issue(CMD_SAMPLE, KEY_W'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
          end
          sent += 1 + n;
        end else begin
          issue(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
          sent++;
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
